FILE: sv/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// No dependencies; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent holds, consequent holds in the same cycle.
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Antecedent holds, consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: sv/rspd_pkg.sv
// Shared types and constants of the packet deframer.
// No dependencies; used by every deframer module.
package rspd_pkg;

  localparam int BUF_BYTES_DEFAULT   = 16384;
  localparam int QUEUE_DEPTH_DEFAULT = 2;
  localparam int LIMIT_W             = 14;

  localparam logic [LIMIT_W-1:0] LIMIT_MAX = 14'd16382;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_END   = 8'h23;
  localparam logic [7:0] CH_ESC   = 8'h7d;
  localparam logic [7:0] CH_INTR  = 8'h03;
  localparam logic [7:0] ESC_XOR  = 8'h20;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_INTR    = 2'd2;

  localparam logic [1:0] STATUS_GOOD     = 2'd0;
  localparam logic [1:0] STATUS_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;
  localparam logic [1:0] STATUS_ESCAPE   = 2'd3;

  localparam logic [1:0] OP_PAYLOAD = 2'd0;
  localparam logic [1:0] OP_END     = 2'd1;
  localparam logic [1:0] OP_INTR    = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
    logic       bad;
    logic       esc;
  } cmd_t;

endpackage

FILE: sv/rsp_packet_deframer.sv
// Remote serial protocol packet deframer, top level.
// Slave stream of link bytes in, master stream of payload/end/interrupt out.
// Input: s_tdata[7:0] is one received byte; s_tready falls only when the
//   command queue is full.
// Output: m_tuser is the kind (0 payload byte, 1 end of packet,
//   2 interrupt request); m_tdata carries data, status, reply_nak, length.
// Config: cfg_data sets the payload limit; cfg_ready is always high. Write
//   only while no packet is in flight.
// Throughput: one byte per cycle sustained while m_tready stays high; the front
//   end framing FSM and the back end count/limit update are each registered.
// Path: the front end writes an accepted byte's result into the queue, and
//   the queue feeds it into the output register on the master side.
// Framing bytes, escapes, checksum digits, junk and over-limit payload bytes
//   give no result; the end result follows the second checksum digit.
// Reset: hunt mode, count cleared, queue and output register empty, limit
//   back to its maximum.
// Stall: while m_tready is low the output register holds, the queue fills,
//   and then s_tready drops until the register drains.
module rsp_packet_deframer #(
  parameter int BUF_BYTES   = rspd_pkg::BUF_BYTES_DEFAULT,
  parameter int QUEUE_DEPTH = rspd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] rx_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,   // data, status, reply_nak, length
  output logic [1:0]                    m_tuser,   // [1:0] kind
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rspd_pkg::LIMIT_W-1:0]  cfg_data   // payload_limit
);
  import rspd_pkg::*;

  cmd_t               f_cmd;
  logic               f_valid;
  logic               f_ready;
  cmd_t               q_cmd;
  logic               q_valid;
  logic               q_ready;
  logic [7:0]         o_data;
  logic [1:0]         o_status;
  logic               o_nak;
  logic [LIMIT_W-1:0] o_length;

  assign cfg_ready = 1'b1;

  rspd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  rspd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  rspd_back #(
    .BUF_BYTES (BUF_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd        (q_cmd),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_data   (o_data),
    .out_status (o_status),
    .out_nak    (o_nak),
    .out_length (o_length)
  );

  assign m_tdata = {7'd0, o_length, o_nak, o_status, o_data};

endmodule

FILE: sv/rspd_front.sv
// Framing front end: hunt, body, checksum digits; emits commands.
// Depends on rspd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rspd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  output logic          cmd_valid,
  output rspd_pkg::cmd_t cmd,
  input  logic          cmd_ready
);
  import rspd_pkg::*;

  localparam logic [1:0] MODE_HUNT  = 2'd0;
  localparam logic [1:0] MODE_BODY  = 2'd1;
  localparam logic [1:0] MODE_CK_HI = 2'd2;
  localparam logic [1:0] MODE_CK_LO = 2'd3;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c inside {[8'h30:8'h39]}) v = 5'(c - 8'h30);
    else if (c inside {[8'h61:8'h66]}) v = 5'(c - 8'h57);
    else if (c inside {[8'h41:8'h46]}) v = 5'(c - 8'h37);
    return v;
  endfunction

  logic [1:0] mode, mode_next;
  logic [7:0] sum, sum_next;
  logic       esc, esc_next;
  logic [4:0] hi, hi_next;
  logic [4:0] lo;
  logic       acc;

  assign in_ready = cmd_ready;
  assign acc      = in_valid && in_ready;
  assign lo       = hex_value(in_byte);

  always_comb begin
    mode_next = mode;
    sum_next  = sum;
    esc_next  = esc;
    hi_next   = hi;
    cmd_valid = 1'b0;
    cmd.op    = OP_PAYLOAD;
    cmd.data  = in_byte;
    cmd.bad   = hi[4] | lo[4] | ({hi[3:0], lo[3:0]} != sum);
    cmd.esc   = esc;
    if (acc) begin
      case (mode)
        MODE_BODY: begin
          if (in_byte == CH_END) begin
            mode_next = MODE_CK_HI;
          end else begin
            sum_next = sum + in_byte;
            if (esc) begin
              esc_next  = 1'b0;
              cmd.data  = in_byte ^ ESC_XOR;
              cmd_valid = 1'b1;
            end else if (in_byte == CH_ESC) begin
              esc_next = 1'b1;
            end else begin
              cmd_valid = 1'b1;
            end
          end
        end
        MODE_CK_HI: begin
          hi_next   = lo;
          mode_next = MODE_CK_LO;
        end
        MODE_CK_LO: begin
          cmd.op    = OP_END;
          cmd_valid = 1'b1;
          mode_next = MODE_HUNT;
        end
        default: begin
          if (in_byte == CH_START) begin
            mode_next = MODE_BODY;
            sum_next  = 8'd0;
            esc_next  = 1'b0;
            hi_next   = 5'd0;
          end else if (in_byte == CH_INTR) begin
            cmd.op    = OP_INTR;
            cmd_valid = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_HUNT;
      sum  <= 8'd0;
      esc  <= 1'b0;
      hi   <= 5'd0;
    end else begin
      mode <= mode_next;
      sum  <= sum_next;
      esc  <= esc_next;
      hi   <= hi_next;
    end
  end

  `ASSERT_NEXT(a_ck_lo_ends, clk, rst, acc && (mode == MODE_CK_LO), mode == MODE_HUNT)

endmodule

FILE: sv/rspd_queue.sv
// Short command queue between framing front end and result back end.
// Depends on rspd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rspd_queue #(
  parameter int DEPTH = rspd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  rspd_pkg::cmd_t wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output rspd_pkg::cmd_t rd_cmd
);
  import rspd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != FULL);
  assign rd_valid = (count != '0);
  assign rd_cmd   = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= FULL)

endmodule

FILE: sv/rspd_back.sv
// Result back end: payload count, limit, status and output register.
// Depends on rspd_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rspd_back #(
  parameter int BUF_BYTES = rspd_pkg::BUF_BYTES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rspd_pkg::LIMIT_W-1:0]  cfg_data,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  rspd_pkg::cmd_t                cmd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_data,
  output logic [1:0]                    out_status,
  output logic                          out_nak,
  output logic [rspd_pkg::LIMIT_W-1:0]  out_length
);
  import rspd_pkg::*;

  localparam int BUF_CAP = BUF_BYTES - 2;
  localparam int CAP     = (BUF_CAP < int'(LIMIT_MAX)) ? BUF_CAP : int'(LIMIT_MAX);
  localparam logic [LIMIT_W-1:0] CAP_V = LIMIT_W'(CAP);

  logic [LIMIT_W-1:0] limit;
  logic [LIMIT_W-1:0] lim;
  logic [LIMIT_W-1:0] count;
  logic               overflow;
  logic               can_load;
  logic               pop;

  assign lim       = (limit > CAP_V) ? CAP_V : limit;
  assign can_load  = !out_valid || out_ready;
  assign cmd_ready = can_load;
  assign pop       = cmd_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= LIMIT_MAX;
      out_valid <= 1'b0;
      count     <= '0;
      overflow  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_data;
      end
      if (can_load) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        out_data   <= 8'd0;
        out_status <= STATUS_GOOD;
        out_nak    <= 1'b0;
        out_length <= '0;
        case (cmd.op)
          OP_PAYLOAD: begin
            if (count < lim) begin
              count     <= count + 1'b1;
              out_valid <= 1'b1;
              out_kind  <= KIND_PAYLOAD;
              out_data  <= cmd.data;
            end else begin
              overflow <= 1'b1;
              count    <= lim + 1'b1;
            end
          end
          OP_END: begin
            out_valid  <= 1'b1;
            out_kind   <= KIND_END;
            out_length <= count;
            if (cmd.bad) begin
              out_status <= STATUS_MISMATCH;
              out_nak    <= 1'b1;
            end else if (overflow) begin
              out_status <= STATUS_TOO_LONG;
            end else if (cmd.esc) begin
              out_status <= STATUS_ESCAPE;
            end
            count    <= '0;
            overflow <= 1'b0;
          end
          OP_INTR: begin
            out_valid <= 1'b1;
            out_kind  <= KIND_INTR;
          end
          default: begin
          end
        endcase
      end
    end
  end

  `ASSERT_NOW(a_payload_counted, clk, rst, out_valid && (out_kind == KIND_PAYLOAD),
              count != '0)
  `ASSERT_NOW(a_nak_iff_mismatch, clk, rst, out_valid,
              out_nak == (out_status == STATUS_MISMATCH))

endmodule
